// ----- src/rng_pkg.sv -----
`timescale 1ns / 1ps

package rng_pkg;

  // action codes carried in the input tuser
  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_TOTAL  = 2'd1;
  localparam logic [1:0] ACT_SHIFT  = 2'd2;
  localparam logic [1:0] ACT_FINISH = 2'd3;

  // configuration register indexes
  localparam logic CFG_FIRST_BYTE    = 1'b0;
  localparam logic CFG_INITIAL_COUNT = 1'b1;

  localparam logic [31:0] RANGE_TOP      = 32'h8000_0000;
  localparam logic [31:0] RANGE_BOTTOM   = 32'h0080_0000;
  localparam logic [31:0] NO_CARRY_LIMIT = 32'h7f80_0000;
  localparam logic [3:0]  PENDING_MAX    = 4'd12;
  localparam logic [2:0]  MAX_ROUNDS     = 3'd4;

  // byte buffer: one item emits at most 21 bytes
  localparam int BUF_AW = 5;

  typedef struct packed {
    logic       clr;
    logic       wr_en;
    logic [7:0] wr_data;
    logic       drain;
    logic       flag;
  } buf_ctrl_t;

endpackage

// ----- src/rng_div.sv -----
`timescale 1ns / 1ps

module rng_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  import rng_pkg::*;

  logic        busy;
  logic [4:0]  cnt;
  logic [15:0] rem;
  logic [15:0] dvs;
  logic [31:0] quo;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;

  // one restoring step per cycle
  always_comb begin
    trial = {rem, quo[31]};
    ge    = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[30:0], ge};
      rem <= ge ? diff[15:0] : trial[15:0];
    end
  end

  assign quotient = quo;

endmodule

// ----- src/rng_obuf.sv -----
`timescale 1ns / 1ps

module rng_obuf (
  input  logic               clk,
  input  logic               rst,
  input  rng_pkg::buf_ctrl_t ctrl,
  output logic               busy,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,  // out_byte
  output logic               m_axis_tlast,
  output logic               m_axis_tuser   // pending_overflow
);
  import rng_pkg::*;

  localparam logic [1:0] OB_IDLE  = 2'd0;
  localparam logic [1:0] OB_FETCH = 2'd1;
  localparam logic [1:0] OB_SHOW  = 2'd2;

  logic [7:0]        mem [2**BUF_AW];
  logic [7:0]        rdata;
  logic [BUF_AW-1:0] wr_ptr;
  logic [BUF_AW-1:0] rd_ptr;
  logic [1:0]        state;
  logic              flag;
  logic              is_last;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_ptr] <= ctrl.wr_data;
    end
    rdata <= mem[rd_ptr];
  end

  assign is_last = rd_ptr == wr_ptr - BUF_AW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= OB_IDLE;
      wr_ptr <= '0;
      rd_ptr <= '0;
      flag   <= 1'b0;
    end else begin
      if (ctrl.clr) begin
        wr_ptr <= '0;
      end else if (ctrl.wr_en) begin
        wr_ptr <= wr_ptr + BUF_AW'(1);
      end
      unique case (state)
        OB_IDLE: begin
          // an item that wrote no bytes sends nothing
          if (ctrl.drain && wr_ptr != '0) begin
            rd_ptr <= '0;
            flag   <= ctrl.flag;
            state  <= OB_FETCH;
          end
        end
        OB_FETCH: state <= OB_SHOW;
        OB_SHOW: begin
          if (m_axis_tready) begin
            if (is_last) begin
              state <= OB_IDLE;
            end else begin
              rd_ptr <= rd_ptr + BUF_AW'(1);
              state  <= OB_FETCH;
            end
          end
        end
        default: state <= OB_IDLE;
      endcase
    end
  end

  assign busy          = state != OB_IDLE;
  assign m_axis_tvalid = state == OB_SHOW;
  assign m_axis_tdata  = rdata;
  assign m_axis_tlast  = is_last;
  assign m_axis_tuser  = flag;

endmodule

// ----- src/range_encoder_unit.sv -----
`timescale 1ns / 1ps

// Byte-oriented 32-bit range encoder.
// Input words arrive on s_axis: tuser holds the action (start, encode with
// total, encode with shift, finish), tdata the symbol frequencies, total and shift.
// Compressed bytes leave on m_axis, one byte per word; tlast marks the last
// byte caused by an input word and tuser carries the sticky overflow flag.
// first_byte and initial_count are set through cfg_we/cfg_index/cfg_data
// and take effect at the next start action.
// Each word runs through a sequencer: up to four renormalize rounds with
// bytes flushed through the pending state, then for a total-based encode
// a serial restoring divide, and for either encode the steps MUL1, MUL2
// and MUL3 on a shared 32x16 multiplier. Bytes are collected in a small
// buffer and streamed out after the word is done, each byte read from the
// buffer before it is shown to the receiver; a word that makes no bytes
// sends nothing. tready stays low until the last byte is taken, so a
// stalled receiver holds the input side. Reset clears the coder to low 0,
// range 0x80000000, held byte, pending count, byte count and both
// registers to 0.
module range_encoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // sym_freq, low_freq, total, shift, zero pad
  input  logic [1:0]  s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,  // pending_overflow
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);
  import rng_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RENORM = 4'd1;
  localparam logic [3:0] ST_PEND   = 4'd2;
  localparam logic [3:0] ST_DIV    = 4'd3;
  localparam logic [3:0] ST_MUL1   = 4'd4;
  localparam logic [3:0] ST_MUL2   = 4'd5;
  localparam logic [3:0] ST_MUL3   = 4'd6;
  localparam logic [3:0] ST_FIN    = 4'd7;
  localparam logic [3:0] ST_FIN2   = 4'd8;
  localparam logic [3:0] ST_TAIL   = 4'd9;
  localparam logic [3:0] ST_DONE   = 4'd10;

  logic [3:0]  state;
  logic [7:0]  first_byte;
  logic [23:0] initial_count;
  logic [31:0] code_low;
  logic [31:0] code_range;
  logic [7:0]  held_byte;
  logic [3:0]  pending_count;
  logic [23:0] byte_count;
  logic        overflow;

  logic [1:0]  action;
  logic [15:0] sym_freq;
  logic [15:0] low_freq;
  logic [15:0] total;
  logic [4:0]  shift;

  logic [2:0]  round;
  logic        carry;
  logic        in_final;
  logic [1:0]  tail_idx;
  logic [7:0]  tail_byte;
  logic [31:0] r;
  logic [31:0] prod;

  logic        accept;
  logic        renorm_go;
  logic        no_carry;
  logic [9:0]  t_val;
  logic [15:0] mul_b;
  logic [31:0] mul_full;
  logic        div_start;
  logic        div_done;
  logic [31:0] div_quo;
  logic        obuf_busy;
  buf_ctrl_t   bctl;

  assign s_axis_tready = state == ST_IDLE && !obuf_busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign renorm_go = round < MAX_ROUNDS && code_range <= RANGE_BOTTOM;
  assign no_carry  = code_low < NO_CARRY_LIMIT;
  assign t_val     = {1'b0, code_low[31:23]}
                   + ((code_low[22:0] >= byte_count[23:1]) ? 10'd1 : 10'd0);

  // shared multiplier: low_freq first, then sym_freq
  assign mul_b    = (state == ST_MUL1) ? low_freq : sym_freq;
  assign mul_full = r * mul_b;

  assign div_start = state == ST_RENORM && !renorm_go && action == ACT_TOTAL;

  rng_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (code_range),
    .divisor  ((total == 16'd0) ? 16'd1 : total),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    bctl.clr     = accept;
    bctl.wr_en   = 1'b0;
    bctl.wr_data = '0;
    bctl.drain   = 1'b0;
    bctl.flag    = overflow;
    unique case (state)
      ST_RENORM: begin
        if (renorm_go && (no_carry || code_low[31])) begin
          bctl.wr_en   = 1'b1;
          bctl.wr_data = no_carry ? held_byte : held_byte + 8'd1;
        end
      end
      ST_PEND: begin
        if (pending_count != 4'd0) begin
          bctl.wr_en   = 1'b1;
          bctl.wr_data = carry ? 8'h00 : 8'hff;
        end
      end
      ST_FIN2: begin
        bctl.wr_en   = 1'b1;
        bctl.wr_data = t_val[8] || t_val[9] ? held_byte + 8'd1 : held_byte;
      end
      ST_TAIL: begin
        bctl.wr_en = 1'b1;
        case (tail_idx)
          2'd0:    bctl.wr_data = tail_byte;
          2'd1:    bctl.wr_data = byte_count[23:16];
          2'd2:    bctl.wr_data = byte_count[15:8];
          default: bctl.wr_data = byte_count[7:0];
        endcase
      end
      ST_DONE: bctl.drain = 1'b1;
      default: ;
    endcase
  end

  rng_obuf u_obuf (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (bctl),
    .busy          (obuf_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      action   <= s_axis_tuser;
      sym_freq <= s_axis_tdata[15:0];
      low_freq <= s_axis_tdata[31:16];
      total    <= s_axis_tdata[47:32];
      shift    <= s_axis_tdata[52:48];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_byte    <= '0;
      initial_count <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FIRST_BYTE) begin
        first_byte <= cfg_data[7:0];
      end else begin
        initial_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      code_low      <= '0;
      code_range    <= RANGE_TOP;
      held_byte     <= '0;
      pending_count <= '0;
      byte_count    <= '0;
      overflow      <= 1'b0;
      round         <= '0;
      carry         <= 1'b0;
      in_final      <= 1'b0;
      tail_idx      <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            round    <= '0;
            in_final <= 1'b0;
            tail_idx <= '0;
            if (s_axis_tuser == ACT_START) begin
              code_low      <= '0;
              code_range    <= RANGE_TOP;
              held_byte     <= first_byte;
              pending_count <= '0;
              byte_count    <= initial_count;
              overflow      <= 1'b0;
            end else begin
              state <= ST_RENORM;
            end
          end
        end
        ST_RENORM: begin
          if (renorm_go) begin
            if (no_carry || code_low[31]) begin
              carry <= !no_carry;
              state <= ST_PEND;
            end else begin
              if (pending_count < PENDING_MAX) begin
                pending_count <= pending_count + 4'd1;
              end else begin
                overflow <= 1'b1;
              end
              code_low   <= {1'b0, code_low[22:0], 8'h00};
              code_range <= {code_range[23:0], 8'h00};
              byte_count <= byte_count + 24'd1;
              round      <= round + 3'd1;
            end
          end else if (action == ACT_TOTAL) begin
            state <= ST_DIV;
          end else if (action == ACT_SHIFT) begin
            r     <= code_range >> shift;
            state <= ST_MUL1;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_PEND: begin
          if (pending_count != 4'd0) begin
            pending_count <= pending_count - 4'd1;
          end else if (in_final) begin
            state <= ST_TAIL;
          end else begin
            held_byte  <= code_low[30:23];
            code_low   <= {1'b0, code_low[22:0], 8'h00};
            code_range <= {code_range[23:0], 8'h00};
            byte_count <= byte_count + 24'd1;
            round      <= round + 3'd1;
            state      <= ST_RENORM;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            r     <= div_quo;
            state <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          prod  <= mul_full;
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          code_low <= code_low + prod;
          prod     <= mul_full;
          state    <= ST_MUL3;
        end
        ST_MUL3: begin
          code_range <= prod;
          state      <= ST_DONE;
        end
        ST_FIN: begin
          byte_count <= byte_count + 24'd5;
          state      <= ST_FIN2;
        end
        ST_FIN2: begin
          // carry into the held byte when the rounded top byte overflows
          carry     <= t_val[8] || t_val[9];
          tail_byte <= t_val[7:0];
          in_final  <= 1'b1;
          state     <= ST_PEND;
        end
        ST_TAIL: begin
          tail_idx <= tail_idx + 2'd1;
          if (tail_idx == 2'd3) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
